FILE: rtl/tcp_option_walker_extractor_top_defines.svh
// Assertion macros for the TCP option walker RTL.
// Included by modules that carry concurrent checks; expects clk and rst_n in scope.
`ifndef TCP_OPTION_WALKER_EXTRACTOR_TOP_DEFINES_SVH
`define TCP_OPTION_WALKER_EXTRACTOR_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Check sampled on clk, muted while rst_n is low.
`define TOWE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check sampled on clk, live through reset as well.
`define TOWE_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TOWE_ASSERT(lbl, prop, msg)
`define TOWE_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

FILE: rtl/towe_pkg.sv
// Package for the TCP option walker: walk phase type, option kinds, length thresholds.
// No dependencies.
`default_nettype none

package towe_pkg;

    localparam int unsigned MAX_AREA_BYTES_DEF = 40;

    localparam logic [7:0] MATCH_KIND_RESET = 8'd254;

    localparam logic [7:0] KIND_EOL = 8'd0;
    localparam logic [7:0] KIND_NOP = 8'd1;

    localparam logic [7:0] MIN_OPTION_LEN = 8'd2;

    localparam logic [7:0] LEN_STAMP      = 8'd6;
    localparam logic [7:0] LEN_SRC_ADDR   = 8'd10;
    localparam logic [7:0] LEN_SRC_PORT   = 8'd12;
    localparam logic [7:0] LEN_DST_ADDR   = 8'd16;
    localparam logic [7:0] LEN_DST_PORT   = 8'd18;

    localparam logic [5:0] POS_SATURATE   = 6'd63;

    // register index, taken from paddr[2]
    localparam logic REG_MATCH_KIND = 1'b0;

    typedef enum logic [3:0] {
        PH_KIND = 4'b0001,
        PH_LEN  = 4'b0010,
        PH_BODY = 4'b0100,
        PH_STOP = 4'b1000
    } walk_phase_t;

endpackage

`default_nettype wire

FILE: rtl/tcp_option_walker_extractor_top.sv
// TCP option walker and record extractor, top level.
// Depends on towe_pkg and tcp_option_walker_extractor_top_defines.svh.
//
// Usage:
//   Input channel (item_valid / item_stall) carries one option-area byte per
//   transfer with the area length and a last-byte flag. Output channel
//   (result_valid / result_stall) carries one record transfer when a byte
//   completes an option of kind match_kind, or when the byte is flagged last
//   (area_done, found_any). Bytes that cause nothing give no transfer.
//   One byte per cycle is taken while the output drains. A byte is held in an
//   input register, walked against the option state, and its result lands in
//   the output register. There is a single walk stage, so a new byte can enter
//   the input register while the previous one is walked.
//   When result_stall holds a waiting result, the input register still takes
//   one byte; item_stall then rises until the result is taken.
//   match_kind sits on an APB port at address 0 (reset 254); write it only
//   while the block is idle.
//   Reset clears the walk and both valid flags, and sets match_kind to 254.
`default_nettype none

`include "tcp_option_walker_extractor_top_defines.svh"

module tcp_option_walker_extractor_top #(
    parameter int unsigned MAX_AREA_BYTES = towe_pkg::MAX_AREA_BYTES_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,

    input  wire logic        item_valid,
    output logic             item_stall,
    input  wire logic [7:0]  data_byte,
    input  wire logic [5:0]  area_length,
    input  wire logic        last_byte,

    output logic             result_valid,
    input  wire logic        result_stall,
    output logic             record_valid,
    output logic      [31:0] stamp,
    output logic      [31:0] source_address,
    output logic      [15:0] source_port,
    output logic      [31:0] dest_address,
    output logic      [15:0] dest_port,
    output logic             area_done,
    output logic             found_any
);

    localparam logic [5:0] AREA_MAX = 6'(MAX_AREA_BYTES);

    // configuration
    logic [7:0] match_kind_reg;

    // input register
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic [5:0] in_alen_reg;
    logic       in_last_reg;

    // walk state
    logic [5:0]           byte_position_reg, byte_position_next;
    towe_pkg::walk_phase_t walk_phase_reg, walk_phase_next;
    logic [7:0]           current_kind_reg, current_kind_next;
    logic [7:0]           current_length_reg, current_length_next;
    logic [7:0]           body_offset_reg, body_offset_next;
    logic [31:0]          held_stamp_reg, held_stamp_next;
    logic [31:0]          held_src_addr_reg, held_src_addr_next;
    logic [15:0]          held_src_port_reg, held_src_port_next;
    logic [31:0]          held_dst_addr_reg, held_dst_addr_next;
    logic [15:0]          held_dst_port_reg, held_dst_port_next;
    logic                 seen_match_reg, seen_match_next;

    // output register
    logic        result_valid_reg;
    logic        record_valid_reg;
    logic [31:0] stamp_reg;
    logic [31:0] source_address_reg;
    logic [15:0] source_port_reg;
    logic [31:0] dest_address_reg;
    logic [15:0] dest_port_reg;
    logic        area_done_reg;
    logic        found_any_reg;

    logic       in_accept;
    logic       proc;
    logic [5:0] alen;
    logic [5:0] remaining;
    logic [7:0] offset_inc;
    logic       complete;
    logic       rec;
    logic       has_result;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign prdata = (paddr[2] == towe_pkg::REG_MATCH_KIND) ? {24'd0, match_kind_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_kind_reg <= towe_pkg::MATCH_KIND_RESET;
        end
        else if (psel && penable && pwrite && pready && (paddr[2] == towe_pkg::REG_MATCH_KIND))
        begin
            match_kind_reg <= pwdata[7:0];
        end
    end

    // ---------------- handshakes ----------------
    assign proc       = in_valid_reg && (!result_valid_reg || !result_stall);
    assign item_stall = in_valid_reg && !proc;
    assign in_accept  = item_valid && !item_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (proc)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_byte_reg <= data_byte;
            in_alen_reg <= area_length;
            in_last_reg <= last_byte;
        end
    end

    // ---------------- walk ----------------
    assign alen       = (in_alen_reg > AREA_MAX) ? AREA_MAX : in_alen_reg;
    assign remaining  = (byte_position_reg < alen) ? (alen - byte_position_reg) : 6'd0;
    assign offset_inc = body_offset_reg + 8'd1;

    always_comb
    begin
        walk_phase_next     = walk_phase_reg;
        current_kind_next   = current_kind_reg;
        current_length_next = current_length_reg;
        body_offset_next    = body_offset_reg;
        held_stamp_next     = held_stamp_reg;
        held_src_addr_next  = held_src_addr_reg;
        held_src_port_next  = held_src_port_reg;
        held_dst_addr_next  = held_dst_addr_reg;
        held_dst_port_next  = held_dst_port_reg;
        complete            = 1'b0;

        unique case (walk_phase_reg)
            towe_pkg::PH_KIND:
            begin
                if ((remaining < 6'd2) || (in_byte_reg == towe_pkg::KIND_EOL))
                begin
                    walk_phase_next = towe_pkg::PH_STOP;
                end
                else if (in_byte_reg != towe_pkg::KIND_NOP)
                begin
                    current_kind_next   = in_byte_reg;
                    current_length_next = 8'd0;
                    body_offset_next    = 8'd0;
                    held_stamp_next     = 32'd0;
                    held_src_addr_next  = 32'd0;
                    held_src_port_next  = 16'd0;
                    held_dst_addr_next  = 32'd0;
                    held_dst_port_next  = 16'd0;
                    walk_phase_next     = towe_pkg::PH_LEN;
                end
            end
            towe_pkg::PH_LEN:
            begin
                if ((in_byte_reg < towe_pkg::MIN_OPTION_LEN) ||
                    (in_byte_reg > ({2'd0, remaining} + 8'd1)))
                begin
                    walk_phase_next = towe_pkg::PH_STOP;
                end
                else
                begin
                    current_length_next = in_byte_reg;
                    if (in_byte_reg == towe_pkg::MIN_OPTION_LEN)
                    begin
                        complete = 1'b1;
                    end
                    else
                    begin
                        walk_phase_next = towe_pkg::PH_BODY;
                    end
                end
            end
            towe_pkg::PH_BODY:
            begin
                priority if (body_offset_reg < 8'd4)
                begin
                    held_stamp_next[8*body_offset_reg[1:0] +: 8] = in_byte_reg;
                end
                else if (body_offset_reg < 8'd8)
                begin
                    held_src_addr_next[8*(2'd3 - body_offset_reg[1:0]) +: 8] = in_byte_reg;
                end
                else if (body_offset_reg < 8'd10)
                begin
                    held_src_port_next[(body_offset_reg[0] ? 0 : 8) +: 8] = in_byte_reg;
                end
                else if (body_offset_reg < 8'd14)
                begin
                    held_dst_addr_next[8*2'(2'd1 - body_offset_reg[1:0]) +: 8] = in_byte_reg;
                end
                else if (body_offset_reg < 8'd16)
                begin
                    held_dst_port_next[(body_offset_reg[0] ? 0 : 8) +: 8] = in_byte_reg;
                end
                else
                begin
                    held_stamp_next = held_stamp_reg;
                end
                body_offset_next = offset_inc;
                if (({1'b0, offset_inc} + 9'd2) >= {1'b0, current_length_reg})
                begin
                    complete = 1'b1;
                end
            end
            towe_pkg::PH_STOP:
            begin
                walk_phase_next = towe_pkg::PH_STOP;
            end
            default:
            begin
                walk_phase_next = towe_pkg::PH_STOP;
            end
        endcase

        rec = complete && (current_kind_reg == match_kind_reg);
        if (complete)
        begin
            walk_phase_next = towe_pkg::PH_KIND;
        end
    end

    assign seen_match_next    = seen_match_reg || rec;
    assign byte_position_next = (byte_position_reg < towe_pkg::POS_SATURATE) ?
                                (byte_position_reg + 6'd1) : byte_position_reg;
    assign has_result         = rec || in_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_position_reg  <= 6'd0;
            walk_phase_reg     <= towe_pkg::PH_KIND;
            current_kind_reg   <= 8'd0;
            current_length_reg <= 8'd0;
            body_offset_reg    <= 8'd0;
            held_stamp_reg     <= 32'd0;
            held_src_addr_reg  <= 32'd0;
            held_src_port_reg  <= 16'd0;
            held_dst_addr_reg  <= 32'd0;
            held_dst_port_reg  <= 16'd0;
            seen_match_reg     <= 1'b0;
        end
        else if (proc)
        begin
            if (in_last_reg)
            begin
                // area finished: rearm
                byte_position_reg  <= 6'd0;
                walk_phase_reg     <= towe_pkg::PH_KIND;
                current_kind_reg   <= 8'd0;
                current_length_reg <= 8'd0;
                body_offset_reg    <= 8'd0;
                held_stamp_reg     <= 32'd0;
                held_src_addr_reg  <= 32'd0;
                held_src_port_reg  <= 16'd0;
                held_dst_addr_reg  <= 32'd0;
                held_dst_port_reg  <= 16'd0;
                seen_match_reg     <= 1'b0;
            end
            else
            begin
                byte_position_reg  <= byte_position_next;
                walk_phase_reg     <= walk_phase_next;
                current_kind_reg   <= current_kind_next;
                current_length_reg <= current_length_next;
                body_offset_reg    <= body_offset_next;
                held_stamp_reg     <= held_stamp_next;
                held_src_addr_reg  <= held_src_addr_next;
                held_src_port_reg  <= held_src_port_next;
                held_dst_addr_reg  <= held_dst_addr_next;
                held_dst_port_reg  <= held_dst_port_next;
                seen_match_reg     <= seen_match_next;
            end
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (proc)
        begin
            result_valid_reg <= has_result;
        end
        else if (!result_stall)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (proc && has_result)
        begin
            record_valid_reg   <= rec;
            stamp_reg          <= (rec && (current_length_next >= towe_pkg::LEN_STAMP)) ?
                                  held_stamp_next : 32'd0;
            source_address_reg <= (rec && (current_length_next >= towe_pkg::LEN_SRC_ADDR)) ?
                                  held_src_addr_next : 32'd0;
            source_port_reg    <= (rec && (current_length_next >= towe_pkg::LEN_SRC_PORT)) ?
                                  held_src_port_next : 16'd0;
            dest_address_reg   <= (rec && (current_length_next >= towe_pkg::LEN_DST_ADDR)) ?
                                  held_dst_addr_next : 32'd0;
            dest_port_reg      <= (rec && (current_length_next >= towe_pkg::LEN_DST_PORT)) ?
                                  held_dst_port_next : 16'd0;
            area_done_reg      <= in_last_reg;
            found_any_reg      <= in_last_reg && seen_match_next;
        end
    end

    assign result_valid   = result_valid_reg;
    assign record_valid   = record_valid_reg;
    assign stamp          = stamp_reg;
    assign source_address = source_address_reg;
    assign source_port    = source_port_reg;
    assign dest_address   = dest_address_reg;
    assign dest_port      = dest_port_reg;
    assign area_done      = area_done_reg;
    assign found_any      = found_any_reg;

    // ---------------- checks ----------------
    `TOWE_ASSERT(a_result_has_cause,
        result_valid_reg |-> (record_valid_reg || area_done_reg),
        "result transfer with neither record nor area end")
    `TOWE_ASSERT(a_found_only_at_end,
        (result_valid_reg && !area_done_reg) |-> !found_any_reg,
        "found_any set before area end")
    `TOWE_ASSERT(a_rearm_after_last,
        (proc && in_last_reg) |=> ((walk_phase_reg == towe_pkg::PH_KIND) &&
            (byte_position_reg == 6'd0) && !seen_match_reg),
        "walk not rearmed after last byte")
    `TOWE_ASSERT_ALWAYS(a_stall_only_when_full,
        item_stall |-> (in_valid_reg && result_valid_reg && result_stall),
        "input stalled with room in the pipeline")
    `TOWE_ASSERT(a_record_fields_clear,
        (result_valid_reg && !record_valid_reg) |-> ((stamp_reg == 32'd0) &&
            (source_address_reg == 32'd0) && (dest_port_reg == 16'd0)),
        "record fields set without a record")

endmodule

`default_nettype wire
